// ----- design/sha1md_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants of the SHA-1 digest engine: beat payloads,
// queue entry, initial chaining values, round constants and round bounds.
// ----------------------------------------------------------------------------
package sha1md_pkg;

   typedef struct packed {
      logic       mode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [63:0] digest_high;
      logic [63:0] digest_mid;
      logic [31:0] digest_low;
   } rsp_type;

   // one big-endian message word; last marks the final word of a message
   typedef struct packed {
      logic        last;
      logic [31:0] word;
   } qent_type;

   localparam logic MODE_ABSORB = 1'b0;
   localparam logic MODE_FINISH = 1'b1;

   localparam int QUEUE_DEPTH = 16;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [31:0] H0 = 32'h67452301;
   localparam logic [31:0] H1 = 32'hefcdab89;
   localparam logic [31:0] H2 = 32'h98badcfe;
   localparam logic [31:0] H3 = 32'h10325476;
   localparam logic [31:0] H4 = 32'hc3d2e1f0;

   localparam logic [31:0] K0 = 32'h5a827999;
   localparam logic [31:0] K1 = 32'h6ed9eba1;
   localparam logic [31:0] K2 = 32'h8f1bbcdc;
   localparam logic [31:0] K3 = 32'hca62c1d6;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   // padding word positions across one or two final blocks
   localparam logic [4:0] PAD_END_ONE  = 5'd15;
   localparam logic [4:0] PAD_END_TWO  = 5'd31;
   localparam logic [5:0] PAD_TWO_FILL = 6'd56;

   localparam logic [6:0] SCHED_ROUNDS = 7'd16;
   localparam logic [6:0] SCHED_LAST   = 7'd15;
   localparam logic [6:0] ROUND_F1     = 7'd20;
   localparam logic [6:0] ROUND_F2     = 7'd40;
   localparam logic [6:0] ROUND_F3     = 7'd60;
   localparam logic [6:0] ROUND_LAST   = 7'd79;
   localparam logic [6:0] ROUND_COUNT  = 7'd80;

endpackage

// ----- design/sha1md_queue.sv -----
// ----------------------------------------------------------------------------
// sha1md_queue
// Word queue between the byte packer and the round unit.
// ----------------------------------------------------------------------------
module sha1md_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sha1md_pkg::qent_type push_data,
   output logic                 full,
   input  logic                 pop,
   output sha1md_pkg::qent_type pop_data,
   output logic                 empty
);
   import sha1md_pkg::*;

   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   qent_type          entry_ff [QUEUE_DEPTH];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full     = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("word queue pushed while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("word queue popped while empty");
   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + QCNT_W'(1))
      else $error("word queue count out of step with pushes");
`endif

endmodule

// ----- design/sha1md_front.sv -----
// ----------------------------------------------------------------------------
// sha1md_front
// Byte packer: takes beats, packs big-endian words, counts message length
// and on finish emits the padding and length words into the queue.
// ----------------------------------------------------------------------------
module sha1md_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sha1md_pkg::req_type  req_data,
   output logic                 q_push,
   output sha1md_pkg::qent_type q_data,
   input  logic                 q_full
);
   import sha1md_pkg::*;

   logic [5:0]  fill_ff, fill_in;
   logic [23:0] acc_ff, acc_in;
   logic [63:0] bitlen_ff, bitlen_in;
   logic        pad_busy_ff, pad_busy_in;
   logic        pad_first_ff, pad_first_in;
   logic        pad_two_ff, pad_two_in;
   logic [4:0]  pad_pos_ff, pad_pos_in;

   logic        accept;
   logic [4:0]  pad_end;
   logic [31:0] first_word;

   assign req_ready = !pad_busy_ff && !q_full;
   assign accept    = req_valid && req_ready;
   assign pad_end   = pad_two_ff ? PAD_END_TWO : PAD_END_ONE;

   // held partial word followed by the pad marker
   always_comb begin
      case (fill_ff[1:0])
         2'd0:    first_word = {PAD_BYTE, 24'h0};
         2'd1:    first_word = {acc_ff[7:0], PAD_BYTE, 16'h0};
         2'd2:    first_word = {acc_ff[15:0], PAD_BYTE, 8'h0};
         2'd3:    first_word = {acc_ff, PAD_BYTE};
         default: first_word = {PAD_BYTE, 24'h0};
      endcase
   end

   always_comb begin
      fill_in      = fill_ff;
      acc_in       = acc_ff;
      bitlen_in    = bitlen_ff;
      pad_busy_in  = pad_busy_ff;
      pad_first_in = pad_first_ff;
      pad_two_in   = pad_two_ff;
      pad_pos_in   = pad_pos_ff;
      q_push       = 1'b0;
      q_data       = '0;
      if (accept) begin
         if (req_data.mode == MODE_ABSORB) begin
            acc_in    = {acc_ff[15:0], req_data.data_byte};
            fill_in   = fill_ff + 6'd1;
            bitlen_in = bitlen_ff + 64'd8;
            if (fill_ff[1:0] == 2'd3) begin
               q_push      = 1'b1;
               q_data.word = {acc_ff, req_data.data_byte};
            end
         end else begin
            pad_busy_in  = 1'b1;
            pad_first_in = 1'b1;
            pad_two_in   = (fill_ff >= PAD_TWO_FILL);
            pad_pos_in   = {1'b0, fill_ff[5:2]};
         end
      end else if (pad_busy_ff && !q_full) begin
         q_push = 1'b1;
         if (pad_first_ff) begin
            q_data.word = first_word;
         end else if (pad_pos_ff == pad_end - 5'd1) begin
            q_data.word = bitlen_ff[63:32];
         end else if (pad_pos_ff == pad_end) begin
            q_data.word = bitlen_ff[31:0];
         end
         q_data.last  = (pad_pos_ff == pad_end);
         pad_first_in = 1'b0;
         pad_pos_in   = pad_pos_ff + 5'd1;
         if (pad_pos_ff == pad_end) begin
            pad_busy_in = 1'b0;
            fill_in     = '0;
            bitlen_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         bitlen_ff    <= '0;
         pad_busy_ff  <= 1'b0;
         pad_first_ff <= 1'b0;
         pad_two_ff   <= 1'b0;
         pad_pos_ff   <= '0;
      end else begin
         fill_ff      <= fill_in;
         bitlen_ff    <= bitlen_in;
         pad_busy_ff  <= pad_busy_in;
         pad_first_ff <= pad_first_in;
         pad_two_ff   <= pad_two_in;
         pad_pos_ff   <= pad_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

endmodule

// ----- design/sha1md_core.sv -----
// ----------------------------------------------------------------------------
// sha1md_core
// Round unit: one SHA-1 round per cycle unless waiting on a queued word;
// rolling 16-word schedule, chaining update after round 79, registered digest.
// ----------------------------------------------------------------------------
module sha1md_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  sha1md_pkg::qent_type q_data,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sha1md_pkg::rsp_type  rsp_data
);
   import sha1md_pkg::*;

   localparam logic ST_ROUND  = 1'b0;
   localparam logic ST_UPDATE = 1'b1;

   logic        state_ff, state_in;
   logic [6:0]  round_ff, round_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [31:0] h_ff [5];
   logic [31:0] h_in [5];
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic        final_ff, final_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        in_sched;
   logic [31:0] w_mix, w_next, w_cur;
   logic [31:0] f_val, k_val, t_val;
   logic        step, upd;
   logic [31:0] h_sum [5];

   assign in_sched = (round_ff < SCHED_ROUNDS);
   assign w_mix    = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
   assign w_next   = {w_mix[30:0], w_mix[31]};
   assign w_cur    = in_sched ? q_data.word : w_next;

   always_comb begin
      if (round_ff < ROUND_F1) begin
         f_val = (b_ff & c_ff) | (~b_ff & d_ff);
         k_val = K0;
      end else if (round_ff < ROUND_F2) begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K1;
      end else if (round_ff < ROUND_F3) begin
         f_val = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k_val = K2;
      end else begin
         f_val = b_ff ^ c_ff ^ d_ff;
         k_val = K3;
      end
   end

   assign t_val = {a_ff[26:0], a_ff[31:27]} + f_val + e_ff + k_val + w_cur;

   // first 16 rounds wait on queued words, the rest run free
   assign step  = (state_ff == ST_ROUND) && (!in_sched || !q_empty);
   assign q_pop = (state_ff == ST_ROUND) && in_sched && !q_empty;
   assign upd   = (state_ff == ST_UPDATE) && (!final_ff || !rsp_valid_ff || rsp_ready);

   assign h_sum[0] = h_ff[0] + a_ff;
   assign h_sum[1] = h_ff[1] + b_ff;
   assign h_sum[2] = h_ff[2] + c_ff;
   assign h_sum[3] = h_ff[3] + d_ff;
   assign h_sum[4] = h_ff[4] + e_ff;

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      h_in         = h_ff;
      w_in         = w_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_ROUND: begin
            if (step) begin
               a_in = t_val;
               b_in = a_ff;
               c_in = {b_ff[1:0], b_ff[31:2]};
               d_in = c_ff;
               e_in = d_ff;
               for (int i = 0; i < 15; i++) begin
                  w_in[i] = w_ff[i + 1];
               end
               w_in[15] = w_cur;
               round_in = round_ff + 7'd1;
               if (round_ff == SCHED_LAST) begin
                  final_in = q_data.last;
               end
               if (round_ff == ROUND_LAST) begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            if (upd) begin
               round_in = '0;
               state_in = ST_ROUND;
               if (final_ff) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.digest_high = {h_sum[0], h_sum[1]};
                  rsp_data_in.digest_mid  = {h_sum[2], h_sum[3]};
                  rsp_data_in.digest_low  = h_sum[4];
                  h_in = '{H0, H1, H2, H3, H4};
                  a_in = H0;
                  b_in = H1;
                  c_in = H2;
                  d_in = H3;
                  e_in = H4;
               end else begin
                  h_in = h_sum;
                  a_in = h_sum[0];
                  b_in = h_sum[1];
                  c_in = h_sum[2];
                  d_in = h_sum[3];
                  e_in = h_sum[4];
               end
            end
         end
         default: begin
            state_in = ST_ROUND;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ROUND;
         round_ff     <= '0;
         a_ff         <= H0;
         b_ff         <= H1;
         c_ff         <= H2;
         d_ff         <= H3;
         e_ff         <= H4;
         h_ff         <= '{H0, H1, H2, H3, H4};
         final_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         a_ff         <= a_in;
         b_ff         <= b_in;
         c_ff         <= c_in;
         d_ff         <= d_in;
         e_ff         <= e_in;
         h_ff         <= h_in;
         final_ff     <= final_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_update_after_last_round: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> (round_ff == ROUND_COUNT))
      else $error("chaining update entered before all rounds ran");
   a_digest_from_final_block: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE && final_ff))
      else $error("digest raised outside a final block update");
   a_block_starts_from_chain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && round_ff == 7'd0) |-> (a_ff == h_ff[0] && e_ff == h_ff[4]))
      else $error("working variables not loaded from chaining words");
`endif

endmodule

// ----- design/sha1_message_digest.sv -----
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 engine: byte beats in, one 160-bit digest beat out per message.
// ----------------------------------------------------------------------------
// A byte beat (mode 0) is taken whenever the 16-word queue has room; a finish
// beat (mode 1) is taken and then the packer pushes the padding words (up to
// 16, or up to 18 when 56 or more bytes of the last block are held) as the
// queue has room, taking no beats meanwhile. The round unit runs one round per
// cycle while it has the block's words: each 64-byte block takes 80 rounds
// plus the chaining update, of which the first 16 rounds follow the arrival
// of the block's words, so the round unit sets the sustained throughput. The
// digest beat is formed in the chaining update of the final block and is held
// in an output register, so the next message is accepted while it waits to
// be taken.
// ----------------------------------------------------------------------------
module sha1_message_digest (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  sha1md_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sha1md_pkg::rsp_type rsp_data
);
   import sha1md_pkg::*;

   logic     q_push;
   logic     q_pop;
   logic     q_full;
   logic     q_empty;
   qent_type q_push_data;
   qent_type q_pop_data;

   sha1md_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_push    (q_push),
      .q_data    (q_push_data),
      .q_full    (q_full)
   );

   sha1md_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty)
   );

   sha1md_core u_core (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_pop_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
